// ===== rtl/i2cms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and codes of the i2c master status sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // operation select of an input beat
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // configuration register indexes
  localparam logic CFG_WRITE_COUNT = 1'b0;
  localparam logic CFG_READ_COUNT  = 1'b1;

  localparam int COUNT_W = 6;

  // controller status codes
  localparam logic [7:0] ST_START_TX     = 8'h08;
  localparam logic [7:0] ST_RSTART_TX    = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
  localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
  localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

  // controller commands of one beat
  typedef struct packed {
    logic tx_load;
    logic set_ack;
    logic clear_ack;
    logic set_stop;
    logic set_start;
    logic clear_irq;
    logic rd_sel;
    logic overrun;
  } cmd_t;

endpackage

// ===== rtl/i2cms_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_store
// byte store with one write port and one registered read port
// ----------------------------------------------------------------------------
module i2cms_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/i2cms_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_seq
// operation decode, status code handling and buffer positions
// ----------------------------------------------------------------------------
module i2cms_seq #(
  parameter int BUF_DEPTH = 32,
  parameter int AW        = 5,
  parameter int PW        = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic [1:0]                  func,
  input  logic [4:0]                  index,
  input  logic [7:0]                  status_code,
  input  logic [i2cms_pkg::COUNT_W-1:0] write_count,
  input  logic [i2cms_pkg::COUNT_W-1:0] read_count,
  output i2cms_pkg::cmd_t             cmd,
  output logic                        send_we,
  output logic [AW-1:0]               send_waddr,
  output logic                        send_re,
  output logic [AW-1:0]               send_raddr,
  output logic                        recv_we,
  output logic [AW-1:0]               recv_waddr,
  output logic                        recv_re,
  output logic [AW-1:0]               recv_raddr
);

  localparam int CW = ((PW > i2cms_pkg::COUNT_W) ? PW : i2cms_pkg::COUNT_W) + 1;

  logic [PW-1:0] send_pos_r, send_pos_nxt;
  logic [PW-1:0] recv_pos_r, recv_pos_nxt;
  logic          idx_ok, send_ok, recv_ok, wr_done;

  assign idx_ok  = (32'(index) < 32'(BUF_DEPTH));
  assign send_ok = (send_pos_r < PW'(BUF_DEPTH));
  assign recv_ok = (recv_pos_r < PW'(BUF_DEPTH));
  assign wr_done = (CW'(send_pos_r) >= CW'(write_count));

  always_comb begin
    logic send_next;
    logic recv_one;
    logic ack_choice;
    send_next    = 1'b0;
    recv_one     = 1'b0;
    ack_choice   = 1'b0;
    cmd          = '0;
    send_we      = 1'b0;
    send_re      = 1'b0;
    recv_we      = 1'b0;
    recv_re      = 1'b0;
    send_waddr   = AW'(index);
    recv_raddr   = AW'(index);
    send_raddr   = AW'(send_pos_r);
    recv_waddr   = AW'(recv_pos_r);
    send_pos_nxt = send_pos_r;
    recv_pos_nxt = recv_pos_r;

    case (func)
      i2cms_pkg::FUNC_LOAD: begin
        send_we     = idx_ok;
        cmd.overrun = !idx_ok;
      end
      i2cms_pkg::FUNC_START: begin
        send_pos_nxt  = '0;
        recv_pos_nxt  = '0;
        cmd.set_start = 1'b1;
      end
      i2cms_pkg::FUNC_STATUS: begin
        cmd.clear_irq = 1'b1;
        case (status_code)
          i2cms_pkg::ST_START_TX, i2cms_pkg::ST_RSTART_TX,
          i2cms_pkg::ST_SLA_W_ACK: begin
            send_next = 1'b1;
          end
          i2cms_pkg::ST_DATA_TX_ACK: begin
            if (wr_done) begin
              cmd.set_ack  = 1'b1;
              cmd.set_stop = 1'b1;
            end else begin
              send_next = 1'b1;
            end
          end
          i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_TX_NACK,
          i2cms_pkg::ST_SLA_R_NACK: begin
            cmd.set_ack  = 1'b1;
            cmd.set_stop = 1'b1;
          end
          i2cms_pkg::ST_ARB_LOST: begin
            cmd.set_ack   = 1'b1;
            cmd.set_start = 1'b1;
          end
          i2cms_pkg::ST_SLA_R_ACK: begin
            ack_choice = 1'b1;
          end
          i2cms_pkg::ST_DATA_RX_ACK: begin
            recv_one   = 1'b1;
            ack_choice = 1'b1;
          end
          i2cms_pkg::ST_DATA_RX_NACK: begin
            recv_one     = 1'b1;
            cmd.set_ack  = 1'b1;
            cmd.set_stop = 1'b1;
          end
          default: begin
            cmd.clear_irq = 1'b0;
          end
        endcase
      end
      default: begin
        recv_re     = idx_ok;
        cmd.rd_sel  = idx_ok;
        cmd.overrun = !idx_ok;
      end
    endcase

    if (send_next) begin
      cmd.set_ack = 1'b1;
      if (send_ok) begin
        cmd.tx_load  = 1'b1;
        send_re      = 1'b1;
        send_pos_nxt = send_pos_r + PW'(1);
      end else begin
        cmd.overrun = 1'b1;
      end
    end

    if (recv_one) begin
      if (recv_ok) begin
        recv_we      = 1'b1;
        recv_pos_nxt = recv_pos_r + PW'(1);
      end else begin
        cmd.overrun = 1'b1;
      end
    end

    // ack decision looks at the position after this beat's store
    if (ack_choice) begin
      if ((CW'(recv_pos_nxt) + CW'(1)) < CW'(read_count)) begin
        cmd.set_ack = 1'b1;
      end else begin
        cmd.clear_ack = 1'b1;
      end
    end

    if (!acc) begin
      send_we      = 1'b0;
      send_re      = 1'b0;
      recv_we      = 1'b0;
      recv_re      = 1'b0;
      send_pos_nxt = send_pos_r;
      recv_pos_nxt = recv_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_pos_r <= '0;
      recv_pos_r <= '0;
    end else begin
      send_pos_r <= send_pos_nxt;
      recv_pos_r <= recv_pos_nxt;
    end
  end

  // positions never pass the buffer depth
  a_send_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    send_pos_r <= PW'(BUF_DEPTH))
    else $error("send position past buffer depth");

  a_recv_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    recv_pos_r <= PW'(BUF_DEPTH))
    else $error("receive position past buffer depth");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && func == i2cms_pkg::FUNC_START |=> send_pos_r == '0 && recv_pos_r == '0)
    else $error("start did not clear positions");

endmodule

// ===== rtl/i2c_master_status_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer
// status code driven sequencer of an i2c master controller
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one beat per operation:
//   load a transmit byte, start a transfer, handle a controller status code,
//   or read back a received byte. every input beat yields exactly one
//   result beat on the output channel (out_valid / out_stall) holding the
//   controller commands, the read-back byte and the overrun flag.
//   cfg_* writes write_count (index 0) and read_count (index 1); cfg_ready
//   is always high. write configuration only while the block is idle.
//   a result passes the registered read port of the buffers (the read stage)
//   and then the output register; throughput one beat per cycle while the
//   receiver does not stall.
//   when the receiver stalls, the output register holds and one more beat
//   is still taken into the read stage; in_stall rises only once both
//   stages are full.
//   reset clears both buffer positions, both counts and the pipeline; the
//   byte buffers are not cleared and read as unknown until written.
// ----------------------------------------------------------------------------
module i2c_master_status_sequencer #(
  parameter int BUF_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [4:0] in_index,
  input  logic [7:0] in_byte_in,
  input  logic [7:0] in_status_code,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_load,
  output logic       out_set_ack,
  output logic       out_clear_ack,
  output logic       out_set_stop,
  output logic       out_set_start,
  output logic       out_clear_irq,
  output logic [7:0] out_read_byte,
  output logic       out_overrun,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [i2cms_pkg::COUNT_W-1:0] cfg_data
);

  // buffer address and position widths (position can hold the depth)
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int PW = $clog2(BUF_DEPTH + 1);

  // configuration registers
  logic [i2cms_pkg::COUNT_W-1:0] write_count_r;
  logic [i2cms_pkg::COUNT_W-1:0] read_count_r;

  // pipeline control
  logic            acc;
  logic            s1_en;
  logic            out_en;
  logic            s1_valid_r;
  i2cms_pkg::cmd_t s1_cmd_r;
  i2cms_pkg::cmd_t cmd;

  // buffer ports
  logic          send_we, send_re, recv_we, recv_re;
  logic [AW-1:0] send_waddr, send_raddr, recv_waddr, recv_raddr;
  logic [7:0]    send_rdata, recv_rdata;

  // result register
  logic       out_valid_r;
  logic [7:0] out_tx_byte_r, out_read_byte_r;
  logic       out_tx_load_r, out_set_ack_r, out_clear_ack_r, out_set_stop_r;
  logic       out_set_start_r, out_clear_irq_r, out_overrun_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_count_r <= '0;
      read_count_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == i2cms_pkg::CFG_WRITE_COUNT) begin
        write_count_r <= cfg_data;
      end else begin
        read_count_r <= cfg_data;
      end
    end
  end

  // each stage moves when the stage after it has room
  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;
  assign acc      = in_valid && s1_en;

  i2cms_seq #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW),
    .PW        (PW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .func        (in_func),
    .index       (in_index),
    .status_code (in_status_code),
    .write_count (write_count_r),
    .read_count  (read_count_r),
    .cmd         (cmd),
    .send_we     (send_we),
    .send_waddr  (send_waddr),
    .send_re     (send_re),
    .send_raddr  (send_raddr),
    .recv_we     (recv_we),
    .recv_waddr  (recv_waddr),
    .recv_re     (recv_re),
    .recv_raddr  (recv_raddr)
  );

  // transmit buffer: loaded by index, read at the send position
  i2cms_store #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_send_store (
    .clk     (clk),
    .we      (send_we),
    .waddr   (send_waddr),
    .wdata   (in_byte_in),
    .re      (send_re),
    .raddr   (send_raddr),
    .rdata_r (send_rdata)
  );

  // receive buffer: written at the receive position, read back by index
  i2cms_store #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_recv_store (
    .clk     (clk),
    .we      (recv_we),
    .waddr   (recv_waddr),
    .wdata   (in_byte_in),
    .re      (recv_re),
    .raddr   (recv_raddr),
    .rdata_r (recv_rdata)
  );

  // read stage: commands wait here while the buffer read completes;
  // buffer read data only changes on accept, so it stays aligned
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r <= cmd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_tx_byte_r   <= s1_cmd_r.tx_load ? send_rdata : 8'h00;
      out_read_byte_r <= s1_cmd_r.rd_sel  ? recv_rdata : 8'h00;
      out_tx_load_r   <= s1_cmd_r.tx_load;
      out_set_ack_r   <= s1_cmd_r.set_ack;
      out_clear_ack_r <= s1_cmd_r.clear_ack;
      out_set_stop_r  <= s1_cmd_r.set_stop;
      out_set_start_r <= s1_cmd_r.set_start;
      out_clear_irq_r <= s1_cmd_r.clear_irq;
      out_overrun_r   <= s1_cmd_r.overrun;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_tx_byte_r;
  assign out_tx_load   = out_tx_load_r;
  assign out_set_ack   = out_set_ack_r;
  assign out_clear_ack = out_clear_ack_r;
  assign out_set_stop  = out_set_stop_r;
  assign out_set_start = out_set_start_r;
  assign out_clear_irq = out_clear_irq_r;
  assign out_read_byte = out_read_byte_r;
  assign out_overrun   = out_overrun_r;

  // a stalled input means both stages hold a beat
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  // ack and nack are never requested together
  a_ack_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_set_ack_r && out_clear_ack_r))
    else $error("set and clear ack in one result");

  // a loaded byte always comes with ack set and the interrupt cleared, never with overrun
  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tx_load_r |-> out_set_ack_r && !out_overrun_r
      && out_clear_irq_r)
    else $error("byte load without ack or with overrun");

  // no transmit byte shown unless it is loaded
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tx_load_r |-> out_tx_byte_r == 8'h00)
    else $error("transmit byte without load");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the i2c master status sequencer: a directed pass over
// every operation and status code, then random write, read and combined
// transfers mixed with noise. a scoreboard predicts the command beat of every
// accepted input beat and compares it field by field with the result channel
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH       = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_BEATS = 230;

  // status codes the sequencer reacts to, used for well-formed noise
  localparam logic [7:0] KNOWN_CODES [0:10] = '{
    i2cms_pkg::ST_START_TX, i2cms_pkg::ST_RSTART_TX, i2cms_pkg::ST_SLA_W_ACK,
    i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_TX_ACK, i2cms_pkg::ST_DATA_TX_NACK,
    i2cms_pkg::ST_ARB_LOST, i2cms_pkg::ST_SLA_R_ACK, i2cms_pkg::ST_SLA_R_NACK,
    i2cms_pkg::ST_DATA_RX_ACK, i2cms_pkg::ST_DATA_RX_NACK
  };

  // one result beat, in port order
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_load;
    logic       set_ack;
    logic       clear_ack;
    logic       set_stop;
    logic       set_start;
    logic       clear_irq;
    logic [7:0] read_byte;
    logic       overrun;
  } cmd_beat_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the sequencer state plus the queue of command
  // beats still owed by the block
  // --------------------------------------------------------------------------
  class cmd_scoreboard;
    logic [7:0]       tx_store [DEPTH];
    logic [7:0]       rx_store [DEPTH];
    logic [DEPTH-1:0] tx_written;
    logic [DEPTH-1:0] rx_written;
    int unsigned      send_pos;
    int unsigned      recv_pos;
    int unsigned      write_count;
    int unsigned      read_count;
    cmd_beat_t        expected_cmds [$];
    int unsigned      mismatches;

    function new();
      tx_written  = '0;
      rx_written  = '0;
      send_pos    = 0;
      recv_pos    = 0;
      write_count = 0;
      read_count  = 0;
      mismatches  = 0;
    endfunction

    function void set_count(logic which, logic [i2cms_pkg::COUNT_W-1:0] value);
      if (which == i2cms_pkg::CFG_WRITE_COUNT) write_count = value;
      else read_count = value;
    endfunction

    // true when this status code would fetch a transmit entry never loaded
    function bit fetches_unloaded(logic [7:0] code);
      bit sends;
      sends = (code == i2cms_pkg::ST_START_TX) || (code == i2cms_pkg::ST_RSTART_TX) ||
              (code == i2cms_pkg::ST_SLA_W_ACK) ||
              (code == i2cms_pkg::ST_DATA_TX_ACK && send_pos < write_count);
      return sends && send_pos < DEPTH && !tx_written[send_pos];
    endfunction

    function void send_next(inout cmd_beat_t r);
      if (send_pos < DEPTH) begin
        r.tx_byte = tx_store[send_pos];
        r.tx_load = 1'b1;
        send_pos++;
      end else begin
        r.overrun = 1'b1;
      end
      r.set_ack = 1'b1;
    endfunction

    function void receive_one(logic [7:0] data, inout cmd_beat_t r);
      if (recv_pos < DEPTH) begin
        rx_store[recv_pos]   = data;
        rx_written[recv_pos] = 1'b1;
        recv_pos++;
      end else begin
        r.overrun = 1'b1;
      end
    endfunction

    // nack the byte that will be the last one of the read
    function void ack_choice(inout cmd_beat_t r);
      if (recv_pos + 1 < read_count) r.set_ack = 1'b1;
      else r.clear_ack = 1'b1;
    endfunction

    function void note_beat(logic [1:0] func, logic [4:0] idx, logic [7:0] data,
                            logic [7:0] code);
      cmd_beat_t r;
      bit known;
      r = '0;
      known = 1'b1;
      case (func)
        i2cms_pkg::FUNC_LOAD: begin
          tx_store[idx]   = data;
          tx_written[idx] = 1'b1;
        end
        i2cms_pkg::FUNC_START: begin
          send_pos    = 0;
          recv_pos    = 0;
          r.set_start = 1'b1;
        end
        i2cms_pkg::FUNC_STATUS: begin
          case (code)
            i2cms_pkg::ST_START_TX, i2cms_pkg::ST_RSTART_TX,
            i2cms_pkg::ST_SLA_W_ACK: send_next(r);
            i2cms_pkg::ST_DATA_TX_ACK: begin
              if (send_pos >= write_count) begin
                r.set_ack  = 1'b1;
                r.set_stop = 1'b1;
              end else begin
                send_next(r);
              end
            end
            i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_TX_NACK,
            i2cms_pkg::ST_SLA_R_NACK: begin
              r.set_ack  = 1'b1;
              r.set_stop = 1'b1;
            end
            i2cms_pkg::ST_ARB_LOST: begin
              r.set_ack   = 1'b1;
              r.set_start = 1'b1;
            end
            i2cms_pkg::ST_SLA_R_ACK: ack_choice(r);
            i2cms_pkg::ST_DATA_RX_ACK: begin
              receive_one(data, r);
              ack_choice(r);
            end
            i2cms_pkg::ST_DATA_RX_NACK: begin
              receive_one(data, r);
              r.set_ack  = 1'b1;
              r.set_stop = 1'b1;
            end
            default: known = 1'b0;
          endcase
          r.clear_irq = known;
        end
        default: r.read_byte = rx_store[idx];
      endcase
      expected_cmds.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(cmd_beat_t act);
      cmd_beat_t exp;
      if (expected_cmds.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %p", $time, act);
        mismatches++;
        return;
      end
      exp = expected_cmds.pop_front();
      check_field("tx_byte", exp.tx_byte, act.tx_byte);
      check_field("tx_load", exp.tx_load, act.tx_load);
      check_field("set_ack", exp.set_ack, act.set_ack);
      check_field("clear_ack", exp.clear_ack, act.clear_ack);
      check_field("set_stop", exp.set_stop, act.set_stop);
      check_field("set_start", exp.set_start, act.set_start);
      check_field("clear_irq", exp.clear_irq, act.clear_irq);
      check_field("read_byte", exp.read_byte, act.read_byte);
      check_field("overrun", exp.overrun, act.overrun);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block hookup, every input known from time zero
  // --------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_func = i2cms_pkg::FUNC_LOAD;
  logic [4:0]                    in_index = '0;
  logic [7:0]                    in_byte_in = '0;
  logic [7:0]                    in_status_code = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_tx_byte;
  logic                          out_tx_load;
  logic                          out_set_ack;
  logic                          out_clear_ack;
  logic                          out_set_stop;
  logic                          out_set_start;
  logic                          out_clear_irq;
  logic [7:0]                    out_read_byte;
  logic                          out_overrun;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_index = i2cms_pkg::CFG_WRITE_COUNT;
  logic [i2cms_pkg::COUNT_W-1:0] cfg_data = '0;

  cmd_scoreboard sb;
  bit            gaps_on = 1'b1;  // random idling of both channels
  int unsigned   beats_sent = 0;
  int unsigned   cycle_count = 0;

  i2c_master_status_sequencer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_index       (in_index),
    .in_byte_in     (in_byte_in),
    .in_status_code (in_status_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_byte    (out_tx_byte),
    .out_tx_load    (out_tx_load),
    .out_set_ack    (out_set_ack),
    .out_clear_ack  (out_clear_ack),
    .out_set_stop   (out_set_stop),
    .out_set_start  (out_set_start),
    .out_clear_irq  (out_clear_irq),
    .out_read_byte  (out_read_byte),
    .out_overrun    (out_overrun),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls at random while gaps are enabled
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 30);
  end

  // result monitor, samples the values that stood before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_tx_byte, out_tx_load, out_set_ack, out_clear_ack, out_set_stop,
                       out_set_start, out_clear_irq, out_read_byte, out_overrun});
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // present one input beat and hold it until the block takes it
  task automatic push_beat(logic [1:0] func, logic [4:0] idx, logic [7:0] data,
                           logic [7:0] code);
    while (gaps_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_index       <= idx;
    in_byte_in     <= data;
    in_status_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(func, idx, data, code);
    beats_sent++;
  endtask

  // keeps the stimulus away from never-written store entries: a send from an
  // unloaded slot is preceded by a load of it, a read-back moves to a slot
  // that holds a received byte, or turns into a load while none does
  task automatic issue(logic [1:0] func, logic [4:0] idx, logic [7:0] data,
                       logic [7:0] code);
    if (func == i2cms_pkg::FUNC_STATUS && sb.fetches_unloaded(code))
      push_beat(i2cms_pkg::FUNC_LOAD, 5'(sb.send_pos), 8'($urandom), 8'($urandom));
    if (func == i2cms_pkg::FUNC_READ && !sb.rx_written[idx]) begin
      if (sb.rx_written == '0) begin
        func = i2cms_pkg::FUNC_LOAD;
      end else begin
        do idx = 5'($urandom); while (!sb.rx_written[idx]);
      end
    end
    push_beat(func, idx, data, code);
  endtask

  task automatic status(logic [7:0] code);
    issue(i2cms_pkg::FUNC_STATUS, 5'($urandom), 8'($urandom), code);
  endtask

  // hold the input channel until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both count registers, only while the block is idle
  task automatic configure(logic [i2cms_pkg::COUNT_W-1:0] wc,
                           logic [i2cms_pkg::COUNT_W-1:0] rc);
    cfg_valid <= 1'b1;
    cfg_index <= i2cms_pkg::CFG_WRITE_COUNT;
    cfg_data  <= wc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_count(i2cms_pkg::CFG_WRITE_COUNT, wc);
    cfg_index <= i2cms_pkg::CFG_READ_COUNT;
    cfg_data  <= rc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_count(i2cms_pkg::CFG_READ_COUNT, rc);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // random sequences
  // --------------------------------------------------------------------------

  // mostly around the configured count, now and then 30 to 40, up to past the store
  function automatic int unsigned run_len(int unsigned count);
    if ($urandom_range(7) == 0) return $urandom_range(30, 40);
    return $urandom_range(0, count + 2);
  endfunction

  task automatic write_transfer();
    int unsigned n;
    n = run_len(sb.write_count);
    repeat ($urandom_range(0, 3))
      issue(i2cms_pkg::FUNC_LOAD, 5'($urandom), 8'($urandom), 8'($urandom));
    issue(i2cms_pkg::FUNC_START, 5'($urandom), 8'($urandom), 8'($urandom));
    status(i2cms_pkg::ST_START_TX);
    status(i2cms_pkg::ST_SLA_W_ACK);
    repeat (n) status(i2cms_pkg::ST_DATA_TX_ACK);
    if ($urandom_range(3) == 0) status(i2cms_pkg::ST_DATA_TX_NACK);
  endtask

  // fresh start, or a repeated start right after a write
  task automatic read_transfer(bit fresh);
    int unsigned k;
    k = run_len(sb.read_count);
    if (fresh) begin
      issue(i2cms_pkg::FUNC_START, 5'($urandom), 8'($urandom), 8'($urandom));
      status(i2cms_pkg::ST_START_TX);
    end else begin
      status(i2cms_pkg::ST_RSTART_TX);
    end
    if ($urandom_range(7) == 0) begin
      status(i2cms_pkg::ST_SLA_R_NACK);
    end else begin
      status(i2cms_pkg::ST_SLA_R_ACK);
      repeat (k) status(i2cms_pkg::ST_DATA_RX_ACK);
      status(i2cms_pkg::ST_DATA_RX_NACK);
    end
    repeat ($urandom_range(0, 3))
      issue(i2cms_pkg::FUNC_READ, 5'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // address phases with no start in between, walks the send position off
  // the end of the store
  task automatic send_hammer();
    repeat ($urandom_range(20, 40)) status(KNOWN_CODES[$urandom_range(0, 2)]);
  endtask

  task automatic noise_burst();
    logic [7:0] code;
    repeat ($urandom_range(1, 6)) begin
      code = $urandom_range(1) ? KNOWN_CODES[$urandom_range(0, 10)] : 8'($urandom);
      issue(2'($urandom), 5'($urandom), 8'($urandom), code);
    end
  endtask

  task automatic random_sequence();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      write_transfer();
    end else if (pick < 62) begin
      read_transfer(1'b1);
    end else if (pick < 80) begin
      write_transfer();
      read_transfer(1'b0);
    end else if (pick < 88) begin
      send_hammer();
    end else begin
      noise_burst();
    end
  endtask

  // --------------------------------------------------------------------------
  // main flow
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_start;
    logic [i2cms_pkg::COUNT_W-1:0] wc;
    logic [i2cms_pkg::COUNT_W-1:0] rc;

    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operation, every status code, field extremes
    configure(6'd2, 6'd2);
    issue(i2cms_pkg::FUNC_LOAD, 5'd0, 8'h00, 8'hff);
    issue(i2cms_pkg::FUNC_LOAD, 5'd31, 8'hff, 8'h00);
    issue(i2cms_pkg::FUNC_LOAD, 5'd1, 8'ha5, 8'h5a);
    issue(i2cms_pkg::FUNC_LOAD, 5'd2, 8'h5a, 8'ha5);
    issue(i2cms_pkg::FUNC_START, 5'd31, 8'hff, 8'hff);
    status(i2cms_pkg::ST_START_TX);
    status(i2cms_pkg::ST_DATA_TX_ACK);    // position below write count: sends
    status(i2cms_pkg::ST_DATA_TX_ACK);    // write count reached: stop
    status(i2cms_pkg::ST_DATA_TX_NACK);
    status(i2cms_pkg::ST_SLA_W_NACK);
    status(i2cms_pkg::ST_SLA_R_NACK);
    status(i2cms_pkg::ST_ARB_LOST);
    status(i2cms_pkg::ST_RSTART_TX);
    status(i2cms_pkg::ST_SLA_W_ACK);
    status(i2cms_pkg::ST_SLA_R_ACK);
    issue(i2cms_pkg::FUNC_STATUS, 5'd0, 8'hff, i2cms_pkg::ST_DATA_RX_ACK);
    issue(i2cms_pkg::FUNC_STATUS, 5'd31, 8'h00, i2cms_pkg::ST_DATA_RX_NACK);
    issue(i2cms_pkg::FUNC_READ, 5'd0, 8'h00, 8'h00);
    issue(i2cms_pkg::FUNC_READ, 5'd1, 8'hff, 8'hff);
    status(8'h00);                        // unknown codes leave everything alone
    status(8'hff);
    issue(i2cms_pkg::FUNC_START, 5'd0, 8'h00, 8'h00);
    drain();

    // random phases: extremes of both counts first, then random settings;
    // phase 2 runs with no idling on either side
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       begin wc = 6'd0;  rc = 6'd0;  end
        1:       begin wc = 6'd32; rc = 6'd32; end
        2:       begin wc = 6'd32; rc = 6'd0;  end
        3:       begin wc = 6'd0;  rc = 6'd32; end
        default: begin
          wc = 6'($urandom_range(0, 32));
          rc = 6'($urandom_range(0, 32));
        end
      endcase
      configure(wc, rc);
      gaps_on = (phase != 2);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) random_sequence();
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_cmds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/i2cms_pkg.sv
rtl/i2cms_store.sv
rtl/i2cms_seq.sv
rtl/i2c_master_status_sequencer.sv
verif/testbench.sv
